@@ src/dsc_pkg.sv @@
// Shared types and constants for the slot completion ring.
// Used by every module under dma_slot_completion_ring; depends on nothing.
package dsc_pkg;

  localparam int SLOT_COUNT   = 128;
  localparam int BUFFER_BYTES = 65536;

  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int BYTES_W = 17;
  localparam int SEQ_W   = 64;
  localparam int TIME_W  = 64;

  // Command queue between front and back.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Opcode values on the input channel.
  localparam logic [2:0] OPC_START    = 3'd0;
  localparam logic [2:0] OPC_STOP     = 3'd1;
  localparam logic [2:0] OPC_COMPLETE = 3'd2;
  localparam logic [2:0] OPC_DEQUEUE  = 3'd3;
  localparam logic [2:0] OPC_REQUEUE  = 3'd4;

  typedef enum logic [2:0] {
    OP_START,
    OP_STOP,
    OP_COMPLETE,
    OP_DEQUEUE,
    OP_REQUEUE,
    OP_BAD
  } op_kind_t;

  typedef enum logic [2:0] {
    RC_OK      = 3'd0,
    RC_BUSY    = 3'd1,
    RC_EMPTY   = 3'd2,
    RC_INVALID = 3'd3,
    RC_NOTRUN  = 3'd4
  } rc_t;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_QUEUED = 2'd1,
    ST_DONE   = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_INFO
  } back_state_t;

  // One classified word, as the back end sees it.
  typedef struct packed {
    op_kind_t             kind;
    logic [SLOT_W-1:0]    slot;
    logic                 slot_ok;
    logic [BYTES_W-1:0]   bytes;
    logic [TIME_W-1:0]    stamp;
  } cmd_t;

  // Per-slot frame info.
  typedef struct packed {
    logic [SEQ_W-1:0]     seq;
    logic [TIME_W-1:0]    stamp;
    logic [BYTES_W-1:0]   bytes;
    logic                 ovf;
  } info_t;

  // One result word.
  typedef struct packed {
    rc_t                  rc;
    logic [SLOT_W-1:0]    slot;
    logic [SEQ_W-1:0]     seq;
    logic [TIME_W-1:0]    stamp;
    logic [BYTES_W-1:0]   bytes;
    logic                 ovf;
    logic                 resub;
    logic                 suball;
    logic                 pending;
    logic                 running;
  } res_t;

endpackage

@@ src/dma_slot_completion_ring.sv @@
// Top level of the receive slot completion ring: front decoder, command
// queue and back end. Depends on dsc_pkg, dsc_front, dsc_cmd_fifo, dsc_back.
//
//   channel  handshake            payload
//   -------  -------------------  -------------------------------------------
//   in       in_valid / in_ready  opcode, slot_number, residue_bytes,
//                                 transfer_error, time_ns
//   out      out_valid/out_ready  result_code, out_slot, frame_sequence,
//                                 frame_time, frame_bytes, frame_overflowed,
//                                 resubmit_slot, submit_all_slots,
//                                 completions_pending, running
//
// Each word passes an issue state (memory reads) and an execute state; a
// dequeue that finds a frame also passes an info state, since the frame info
// read is addressed by the slot number read from the completion ring.
// Reset is synchronous; all slots read as free and the ring is empty at once,
// with no clearing pass. A start or stop retypes every slot at once.
// A two-word command queue keeps the input open while the back end waits on
// a stalled output; the result register holds until out_ready.
module dma_slot_completion_ring (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [7:0]  slot_number,
  input  logic [31:0] residue_bytes,
  input  logic        transfer_error,
  input  logic [63:0] time_ns,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_code,
  output logic [dsc_pkg::SLOT_W-1:0] out_slot,
  output logic [63:0] frame_sequence,
  output logic [63:0] frame_time,
  output logic [16:0] frame_bytes,
  output logic        frame_overflowed,
  output logic        resubmit_slot,
  output logic        submit_all_slots,
  output logic        completions_pending,
  output logic        running
);
  import dsc_pkg::*;

  cmd_t front_cmd;
  cmd_t q_data;
  logic q_valid;
  logic q_pop;
  res_t res;

  // Classify the incoming word.
  dsc_front u_front (
    .opcode         (opcode),
    .slot_number    (slot_number),
    .residue_bytes  (residue_bytes),
    .transfer_error (transfer_error),
    .time_ns        (time_ns),
    .cmd            (front_cmd)
  );

  // Hold classified words until the back end is free.
  dsc_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_data)
  );

  // Execute one word at a time against the slot memories.
  dsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // Split the result word onto the ports.
  assign result_code         = res.rc;
  assign out_slot            = res.slot;
  assign frame_sequence      = res.seq;
  assign frame_time          = res.stamp;
  assign frame_bytes         = res.bytes;
  assign frame_overflowed    = res.ovf;
  assign resubmit_slot       = res.resub;
  assign submit_all_slots    = res.suball;
  assign completions_pending = res.pending;
  assign running             = res.running;

endmodule

@@ src/dsc_front.sv @@
// Front end: decodes the opcode, checks the slot range and works out the
// frame byte count. Depends on dsc_pkg.
module dsc_front (
  input  logic [2:0]  opcode,
  input  logic [7:0]  slot_number,
  input  logic [31:0] residue_bytes,
  input  logic        transfer_error,
  input  logic [63:0] time_ns,
  output dsc_pkg::cmd_t cmd
);
  import dsc_pkg::*;

  logic [31:0] short_bytes;
  logic        oversized;
  op_kind_t    kind;

  assign short_bytes = 32'(BUFFER_BYTES) - residue_bytes;
  assign oversized   = residue_bytes > 32'(BUFFER_BYTES);

  always_comb begin
    case (opcode)
      OPC_START:    kind = OP_START;
      OPC_STOP:     kind = OP_STOP;
      OPC_COMPLETE: kind = OP_COMPLETE;
      OPC_DEQUEUE:  kind = OP_DEQUEUE;
      OPC_REQUEUE:  kind = OP_REQUEUE;
      default:      kind = OP_BAD;
    endcase
  end

  always_comb begin
    cmd.kind    = kind;
    cmd.slot    = slot_number[SLOT_W-1:0];
    cmd.slot_ok = {24'd0, slot_number} < 32'(SLOT_COUNT);
    // Full buffer on an error or a residue larger than the buffer.
    cmd.bytes   = (transfer_error || oversized) ? BYTES_W'(BUFFER_BYTES)
                                                : short_bytes[BYTES_W-1:0];
    cmd.stamp   = time_ns;
  end

endmodule

@@ src/dsc_cmd_fifo.sv @@
// Short command queue between front and back end.
// Depends on dsc_pkg.
module dsc_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  dsc_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output dsc_pkg::cmd_t pop_data
);
  import dsc_pkg::*;

  cmd_t                  entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = count != CMDQ_CNT_W'(CMDQ_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/dsc_back.sv @@
// Back end: slot state, frame info and completion ring memories, the
// sequencer that executes one command at a time, and the result register.
// Depends on dsc_pkg.
module dsc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_pop,
  input  dsc_pkg::cmd_t q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dsc_pkg::res_t res
);
  import dsc_pkg::*;

  // Memories.
  slot_st_t          state_mem [SLOT_COUNT];
  info_t             info_mem  [SLOT_COUNT];
  logic [SLOT_W-1:0] ring_mem  [SLOT_COUNT];

  slot_st_t          state_rd;
  info_t             info_rd;
  logic [SLOT_W-1:0] ring_rd;

  // Control and ring state.
  back_state_t       state, state_next;
  cmd_t              cmd;
  logic              capture_on, capture_on_next;
  logic [SLOT_W-1:0] head, head_next;
  logic [SLOT_W-1:0] tail, tail_next;
  logic [SEQ_W-1:0]  frame_counter, frame_counter_next;
  slot_st_t          bulk_state, bulk_state_next;
  logic [SLOT_COUNT-1:0] fresh;

  // Per-cycle controls.
  logic              commit;
  logic              info_rd_en;
  logic              fresh_clear;
  logic              st_we;
  logic [SLOT_W-1:0] st_waddr;
  slot_st_t          st_wdata;
  logic              info_we;
  info_t             info_wdata;
  logic              ring_we;
  res_t              res_next;

  logic              out_free;
  logic [SLOT_W-1:0] head_inc;
  logic [SLOT_W-1:0] tail_inc;
  logic              ring_full;
  slot_st_t          cur_st;

  assign out_free  = !out_valid || out_ready;
  assign head_inc  = (head == SLOT_W'(SLOT_COUNT - 1)) ? '0 : head + 1'b1;
  assign tail_inc  = (tail == SLOT_W'(SLOT_COUNT - 1)) ? '0 : tail + 1'b1;
  assign ring_full = head_inc == tail;
  // A slot not written since the last start or stop holds the bulk state.
  assign cur_st    = fresh[cmd.slot] ? state_rd : bulk_state;

  always_comb begin
    state_next         = state;
    q_pop              = 1'b0;
    commit             = 1'b0;
    info_rd_en         = 1'b0;
    fresh_clear        = 1'b0;
    capture_on_next    = capture_on;
    head_next          = head;
    tail_next          = tail;
    frame_counter_next = frame_counter;
    bulk_state_next    = bulk_state;
    st_we              = 1'b0;
    st_waddr           = cmd.slot;
    st_wdata           = ST_FREE;
    info_we            = 1'b0;
    info_wdata.seq     = frame_counter + 1'b1;
    info_wdata.stamp   = cmd.stamp;
    info_wdata.bytes   = cmd.bytes;
    info_wdata.ovf     = ring_full;
    ring_we            = 1'b0;
    res_next           = '0;
    res_next.rc        = RC_OK;

    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = BK_EXEC;
        end
      end

      BK_EXEC: begin
        if (cmd.kind == OP_DEQUEUE && head != tail) begin
          // Fetch the info of the oldest slot first.
          info_rd_en = 1'b1;
          state_next = BK_INFO;
        end else if (out_free) begin
          commit     = 1'b1;
          state_next = BK_IDLE;
          case (cmd.kind)
            OP_START: begin
              if (capture_on) begin
                res_next.rc = RC_BUSY;
              end else begin
                capture_on_next = 1'b1;
                head_next       = '0;
                tail_next       = '0;
                bulk_state_next = ST_QUEUED;
                fresh_clear     = 1'b1;
                res_next.suball = 1'b1;
              end
            end
            OP_STOP: begin
              capture_on_next = 1'b0;
              bulk_state_next = ST_FREE;
              fresh_clear     = 1'b1;
            end
            OP_COMPLETE: begin
              if (!cmd.slot_ok) begin
                res_next.rc = RC_INVALID;
              end else if (!capture_on) begin
                st_we       = 1'b1;
                st_wdata    = ST_FREE;
                res_next.rc = RC_NOTRUN;
              end else begin
                frame_counter_next = frame_counter + 1'b1;
                info_we            = 1'b1;
                st_we              = 1'b1;
                if (ring_full) begin
                  // Ring full: hand the slot straight back to the engine.
                  st_wdata       = ST_QUEUED;
                  res_next.resub = 1'b1;
                  res_next.slot  = cmd.slot;
                end else begin
                  st_wdata  = ST_DONE;
                  ring_we   = 1'b1;
                  head_next = head_inc;
                end
              end
            end
            OP_DEQUEUE: begin
              res_next.rc = RC_EMPTY;
            end
            OP_REQUEUE: begin
              if (!cmd.slot_ok) begin
                res_next.rc = RC_INVALID;
              end else if (!capture_on) begin
                res_next.rc = RC_NOTRUN;
              end else if (cur_st == ST_QUEUED) begin
                res_next.rc = RC_BUSY;
              end else begin
                st_we    = 1'b1;
                st_wdata = ST_QUEUED;
              end
            end
            default: begin
              res_next.rc = RC_INVALID;
            end
          endcase
        end
      end

      BK_INFO: begin
        if (out_free) begin
          commit         = 1'b1;
          state_next     = BK_IDLE;
          tail_next      = tail_inc;
          st_we          = 1'b1;
          st_waddr       = ring_rd;
          st_wdata       = ST_FREE;
          res_next.slot  = ring_rd;
          res_next.seq   = info_rd.seq;
          res_next.stamp = info_rd.stamp;
          res_next.bytes = info_rd.bytes;
          res_next.ovf   = info_rd.ovf;
        end
      end

      default: begin
        state_next = BK_IDLE;
      end
    endcase

    res_next.pending = head_next != tail_next;
    res_next.running = capture_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_on    <= 1'b0;
      head          <= '0;
      tail          <= '0;
      frame_counter <= '0;
      bulk_state    <= ST_FREE;
      fresh         <= '0;
      out_valid     <= 1'b0;
    end else begin
      capture_on    <= capture_on_next;
      head          <= head_next;
      tail          <= tail_next;
      frame_counter <= frame_counter_next;
      bulk_state    <= bulk_state_next;
      if (fresh_clear) begin
        fresh <= '0;
      end else if (st_we) begin
        fresh[st_waddr] <= 1'b1;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_data;
    end
    if (commit) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      state_mem[st_waddr] <= st_wdata;
    end
    if (q_pop) begin
      state_rd <= state_mem[q_data.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[head] <= cmd.slot;
    end
    if (q_pop) begin
      ring_rd <= ring_mem[tail];
    end
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[cmd.slot] <= info_wdata;
    end
    if (info_rd_en) begin
      info_rd <= info_mem[ring_rd];
    end
  end

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    commit |-> (!out_valid || out_ready))
    else $error("result committed over an unread result");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == BK_IDLE))
    else $error("command taken while another is in flight");

  a_info_then_result: assert property (@(posedge clk) disable iff (rst)
    (state == BK_INFO && out_free) |=> (out_valid && state == BK_IDLE))
    else $error("dequeue result not delivered after info read");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (32'(head) < SLOT_COUNT) && (32'(tail) < SLOT_COUNT))
    else $error("ring pointer out of range");

  a_tail_moves_on_pop: assert property (@(posedge clk) disable iff (rst)
    (state == BK_INFO && out_free) |=> (tail == $past(tail_inc)))
    else $error("tail not advanced by dequeue");

endmodule

@@ sim/slot_ring_checker.sv @@
`timescale 1ns / 100ps
// Result checker for dma_slot_completion_ring: tracks slot states, frame info and the
// completion ring, then compares every result word. Depends on dsc_pkg.
module slot_ring_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [7:0]  slot_number,
  input  logic [31:0] residue_bytes,
  input  logic        transfer_error,
  input  logic [63:0] time_ns,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  result_code,
  input  logic [dsc_pkg::SLOT_W-1:0] out_slot,
  input  logic [63:0] frame_sequence,
  input  logic [63:0] frame_time,
  input  logic [16:0] frame_bytes,
  input  logic        frame_overflowed,
  input  logic        resubmit_slot,
  input  logic        submit_all_slots,
  input  logic        completions_pending,
  input  logic        running,
  output int          fail_count,
  output int          owed_count
);
  import dsc_pkg::*;

  slot_st_t           slot_phase [SLOT_COUNT];
  logic [SEQ_W-1:0]   slot_seq   [SLOT_COUNT];
  logic [TIME_W-1:0]  slot_stamp [SLOT_COUNT];
  logic [BYTES_W-1:0] slot_bytes [SLOT_COUNT];
  logic               slot_ovf   [SLOT_COUNT];
  logic [SLOT_W-1:0]  done_ring  [SLOT_COUNT];
  int                 ring_head;
  int                 ring_tail;
  logic               capture_on;
  logic [63:0]        frame_counter;

  res_t owed_results[$];
  int   fails;

  initial begin
    foreach (slot_phase[i]) begin
      slot_phase[i] = ST_FREE;
      slot_seq[i]   = '0;
      slot_stamp[i] = '0;
      slot_bytes[i] = '0;
      slot_ovf[i]   = 1'b0;
      done_ring[i]  = '0;
    end
    ring_head     = 0;
    ring_tail     = 0;
    capture_on    = 1'b0;
    frame_counter = '0;
    fails         = 0;
  end

  // Apply one command word to the tracked ring and return the result it yields.
  function automatic res_t step_ring(input logic [2:0] op, input logic [7:0] slot_in,
                                     input logic [31:0] residue, input logic err,
                                     input logic [63:0] stamp);
    res_t              r;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] popped;
    logic [31:0]       size32;
    int                nxt;
    r = '0;
    r.rc = RC_OK;
    s = slot_in[SLOT_W-1:0];
    case (op)
      OPC_START: begin
        if (capture_on) begin
          r.rc = RC_BUSY;
        end else begin
          capture_on = 1'b1;
          ring_head  = 0;
          ring_tail  = 0;
          foreach (slot_phase[i]) slot_phase[i] = ST_QUEUED;
          r.suball = 1'b1;
        end
      end
      OPC_STOP: begin
        capture_on = 1'b0;
        foreach (slot_phase[i]) slot_phase[i] = ST_FREE;
      end
      OPC_COMPLETE: begin
        if (slot_in >= SLOT_COUNT) begin
          r.rc = RC_INVALID;
        end else if (!capture_on) begin
          slot_phase[s] = ST_FREE;
          r.rc = RC_NOTRUN;
        end else begin
          // full buffer on an error or a residue larger than the buffer
          if (!err && residue <= BUFFER_BYTES) size32 = BUFFER_BYTES - residue;
          else size32 = BUFFER_BYTES;
          frame_counter = frame_counter + 1;
          slot_seq[s]   = frame_counter;
          slot_stamp[s] = stamp;
          slot_bytes[s] = size32[BYTES_W-1:0];
          nxt = (ring_head + 1) % SLOT_COUNT;
          if (nxt == ring_tail) begin
            slot_ovf[s]   = 1'b1;
            slot_phase[s] = ST_QUEUED;
            r.resub = 1'b1;
            r.slot  = s;
          end else begin
            slot_ovf[s]          = 1'b0;
            slot_phase[s]        = ST_DONE;
            done_ring[ring_head] = s;
            ring_head            = nxt;
          end
        end
      end
      OPC_DEQUEUE: begin
        if (ring_head == ring_tail) begin
          r.rc = RC_EMPTY;
        end else begin
          popped    = done_ring[ring_tail];
          ring_tail = (ring_tail + 1) % SLOT_COUNT;
          r.slot    = popped;
          r.seq     = slot_seq[popped];
          r.stamp   = slot_stamp[popped];
          r.bytes   = slot_bytes[popped];
          r.ovf     = slot_ovf[popped];
          slot_phase[popped] = ST_FREE;
        end
      end
      OPC_REQUEUE: begin
        if (slot_in >= SLOT_COUNT) r.rc = RC_INVALID;
        else if (!capture_on) r.rc = RC_NOTRUN;
        else if (slot_phase[s] == ST_QUEUED) r.rc = RC_BUSY;
        else slot_phase[s] = ST_QUEUED;
      end
      default: r.rc = RC_INVALID;
    endcase
    r.pending = (ring_head != ring_tail);
    r.running = capture_on;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      // compare first: a word accepted at this edge cannot have its result out yet
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("result word arrived with none expected (code %0d)", result_code);
          fails++;
        end else begin
          want = owed_results.pop_front();
          check_field("result_code", 64'(want.rc), 64'(result_code));
          check_field("out_slot", 64'(want.slot), 64'(out_slot));
          check_field("frame_sequence", want.seq, frame_sequence);
          check_field("frame_time", want.stamp, frame_time);
          check_field("frame_bytes", 64'(want.bytes), 64'(frame_bytes));
          check_field("frame_overflowed", 64'(want.ovf), 64'(frame_overflowed));
          check_field("resubmit_slot", 64'(want.resub), 64'(resubmit_slot));
          check_field("submit_all_slots", 64'(want.suball), 64'(submit_all_slots));
          check_field("completions_pending", 64'(want.pending),
                      64'(completions_pending));
          check_field("running", 64'(want.running), 64'(running));
        end
      end
      if (in_valid && in_ready)
        owed_results.push_back(step_ring(opcode, slot_number, residue_bytes,
                                         transfer_error, time_ns));
    end
    fail_count <= fails;
    owed_count <= owed_results.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Top of the dma_slot_completion_ring bench: clock, reset, command words and verdict.
// Depends on dsc_pkg, dma_slot_completion_ring and slot_ring_checker.
module testbench;
  import dsc_pkg::*;

  // Opcodes the block does not define; each must come back with the invalid code.
  localparam logic [2:0] OPC_RSVD_A = 3'd5;
  localparam logic [2:0] OPC_RSVD_B = 3'd6;
  localparam logic [2:0] OPC_RSVD_C = 3'd7;

  // Hard limit for the slowest honest run, with a wide margin.
  localparam int CYCLE_LIMIT = 200000;
  // Drain time after the last result, before the verdict.
  localparam int DRAIN_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode = '0;
  logic [7:0]  slot_number = '0;
  logic [31:0] residue_bytes = '0;
  logic        transfer_error = 1'b0;
  logic [63:0] time_ns = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  result_code;
  logic [SLOT_W-1:0] out_slot;
  logic [63:0] frame_sequence;
  logic [63:0] frame_time;
  logic [16:0] frame_bytes;
  logic        frame_overflowed;
  logic        resubmit_slot;
  logic        submit_all_slots;
  logic        completions_pending;
  logic        running;

  int fail_count;
  int owed_count;
  int cycle_count = 0;

  // Idle rates in percent, changed per phase by the stimulus.
  int snd_idle_pct = 21;
  int rcv_idle_pct = 63;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dma_slot_completion_ring dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .slot_number(slot_number), .residue_bytes(residue_bytes),
    .transfer_error(transfer_error), .time_ns(time_ns),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_code(result_code), .out_slot(out_slot),
    .frame_sequence(frame_sequence), .frame_time(frame_time),
    .frame_bytes(frame_bytes), .frame_overflowed(frame_overflowed),
    .resubmit_slot(resubmit_slot), .submit_all_slots(submit_all_slots),
    .completions_pending(completions_pending), .running(running)
  );

  slot_ring_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .slot_number(slot_number), .residue_bytes(residue_bytes),
    .transfer_error(transfer_error), .time_ns(time_ns),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_code(result_code), .out_slot(out_slot),
    .frame_sequence(frame_sequence), .frame_time(frame_time),
    .frame_bytes(frame_bytes), .frame_overflowed(frame_overflowed),
    .resubmit_slot(resubmit_slot), .submit_all_slots(submit_all_slots),
    .completions_pending(completions_pending), .running(running),
    .fail_count(fail_count), .owed_count(owed_count)
  );

  // Stall the result channel at random; a zero rate keeps ready high.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("cycle limit of %0d reached", CYCLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Drive one command word and hold it until the block takes it. Valid stays
  // high after acceptance; the next call either replaces the payload or drops
  // valid for an idle gap, so each step sees at most one assignment to it.
  task automatic send_word(input logic [2:0] op, input logic [7:0] slot,
                           input logic [31:0] residue, input logic err,
                           input logic [63:0] stamp);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    slot_number    <= slot;
    residue_bytes  <= residue;
    transfer_error <= err;
    time_ns        <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Residues cluster around the buffer size so the clamp edge is hit often.
  function automatic logic [31:0] pick_residue();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return $urandom_range(BUFFER_BYTES);
    if (pick < 80) return $urandom_range(BUFFER_BYTES + 2, BUFFER_BYTES - 2);
    return $urandom;
  endfunction

  // Mostly valid slots; now and then one past the ring.
  function automatic logic [7:0] pick_slot();
    if ($urandom_range(99) < 92) return 8'($urandom_range(SLOT_COUNT - 1));
    return 8'($urandom_range(255, SLOT_COUNT));
  endfunction

  // One word of a random capture session: mostly completions, dequeues and
  // requeues, with occasional start/stop and raw noise.
  task automatic send_session_word();
    int          pick;
    logic [2:0]  op;
    logic [63:0] stamp;
    pick  = $urandom_range(99);
    stamp = {$urandom, $urandom};
    if (pick < 8) begin
      send_word(3'($urandom_range(7)), 8'($urandom_range(255)), $urandom,
                1'($urandom_range(1)), stamp);
    end else if (pick < 14) begin
      send_word(OPC_STOP, 8'($urandom_range(255)), $urandom, 1'($urandom_range(1)), stamp);
    end else if (pick < 22) begin
      send_word(OPC_START, 8'($urandom_range(255)), $urandom, 1'($urandom_range(1)), stamp);
    end else begin
      pick = $urandom_range(99);
      if (pick < 50) op = OPC_COMPLETE;
      else if (pick < 80) op = OPC_DEQUEUE;
      else op = OPC_REQUEUE;
      send_word(op, pick_slot(), pick_residue(), ($urandom_range(7) == 0), stamp);
    end
  endtask

  initial begin
    int i;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // ---- directed words (sender 21%, receiver 63% idle) ----
    // idle block: empty dequeue, completion and requeue while stopped, bad slot
    send_word(OPC_DEQUEUE, 8'd0, 32'd0, 1'b0, 64'd0);
    send_word(OPC_COMPLETE, 8'd5, 32'd10, 1'b0, 64'd1);
    send_word(OPC_REQUEUE, 8'd3, 32'd0, 1'b0, 64'd0);
    send_word(OPC_REQUEUE, 8'd200, 32'd0, 1'b0, 64'd0);
    // undefined opcodes, all other fields at their maximum
    send_word(OPC_RSVD_A, 8'hFF, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OPC_RSVD_B, 8'hFF, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OPC_RSVD_C, 8'hFF, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    // start, then a second start while running is refused as busy
    send_word(OPC_START, 8'd0, 32'd0, 1'b0, 64'd0);
    send_word(OPC_START, 8'd0, 32'd0, 1'b0, 64'd0);
    // byte counts: full buffer, empty buffer, oversized residue, engine error
    send_word(OPC_COMPLETE, 8'd0, 32'd0, 1'b0, 64'd0);
    send_word(OPC_COMPLETE, 8'(SLOT_COUNT - 1), BUFFER_BYTES, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OPC_COMPLETE, 8'd1, BUFFER_BYTES + 1, 1'b0, 64'h1234_5678_9ABC_DEF0);
    send_word(OPC_COMPLETE, 8'd2, 32'd100, 1'b1, 64'h8000_0000_0000_0001);
    // slot numbers past the ring
    send_word(OPC_COMPLETE, 8'(SLOT_COUNT), 32'd0, 1'b0, 64'd7);
    send_word(OPC_COMPLETE, 8'hFF, 32'd0, 1'b0, 64'd7);
    // complete a slot that already waits in the ring; its state is not checked
    send_word(OPC_COMPLETE, 8'd0, 32'hFFFF_FFFF, 1'b0, 64'd42);
    // requeue a completed slot, then again (busy), then a queued one (busy)
    send_word(OPC_REQUEUE, 8'(SLOT_COUNT - 1), 32'd0, 1'b0, 64'd0);
    send_word(OPC_REQUEUE, 8'(SLOT_COUNT - 1), 32'd0, 1'b0, 64'd0);
    send_word(OPC_REQUEUE, 8'd3, 32'd0, 1'b0, 64'd0);
    send_word(OPC_DEQUEUE, 8'd0, 32'd0, 1'b0, 64'd0);
    send_word(OPC_DEQUEUE, 8'd0, 32'd0, 1'b0, 64'd0);
    // stop keeps the ring; dequeue still works, completion is refused
    send_word(OPC_STOP, 8'd0, 32'd0, 1'b0, 64'd0);
    send_word(OPC_DEQUEUE, 8'd0, 32'd0, 1'b0, 64'd0);
    send_word(OPC_COMPLETE, 8'd9, 32'd0, 1'b0, 64'd9);
    // restart empties the ring
    send_word(OPC_START, 8'd0, 32'd0, 1'b0, 64'd0);
    send_word(OPC_DEQUEUE, 8'd0, 32'd0, 1'b0, 64'd0);

    // ---- random sessions, same idle rates ----
    for (i = 0; i < 80; i++) send_session_word();

    // ---- flood (sender 63%, receiver 21% idle): overrun the ring, then drain ----
    snd_idle_pct = 63;
    rcv_idle_pct = 21;
    send_word(OPC_STOP, 8'($urandom_range(255)), $urandom, 1'($urandom_range(1)),
              {$urandom, $urandom});
    send_word(OPC_START, 8'($urandom_range(255)), $urandom, 1'($urandom_range(1)),
              {$urandom, $urandom});
    // the ring holds one entry less than there are slots; push past that
    for (i = 0; i < SLOT_COUNT + 8; i++)
      send_word(OPC_COMPLETE, 8'($urandom_range(SLOT_COUNT - 1)), pick_residue(),
                ($urandom_range(7) == 0), {$urandom, $urandom});
    for (i = 0; i < SLOT_COUNT + 2; i++)
      send_word(OPC_DEQUEUE, 8'($urandom_range(255)), $urandom, 1'($urandom_range(1)),
                {$urandom, $urandom});

    // ---- random sessions at full rate ----
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    for (i = 0; i < 80; i++) send_session_word();
    in_valid <= 1'b0;

    // wait for every owed result, then let the pipeline settle
    while (owed_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (owed_count != 0) $error("%0d result words never arrived", owed_count);
    if (fail_count == 0 && owed_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/dsc_pkg.sv
src/dsc_front.sv
src/dsc_cmd_fifo.sv
src/dsc_back.sv
src/dma_slot_completion_ring.sv
sim/slot_ring_checker.sv
sim/testbench.sv
